>>> rtl/core/tpls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpls_pkg
// Shared types and constants for the three-phase loss and sequence detector.
// ----------------------------------------------------------------------------
package tpls_pkg;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_EDGE = 1'b1
    } t_func;

    localparam int CFG_INDEX_WIDTH = 2;
    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    localparam t_cfg_index CFG_LOSS_LIMIT     = t_cfg_index'(0);
    localparam t_cfg_index CFG_SEQUENCE_LIMIT = t_cfg_index'(1);

    localparam int CFG_DATA_WIDTH  = 16;
    localparam int LOSS_LIM_WIDTH  = 16;
    localparam int SEQ_LIM_WIDTH   = 8;
    localparam int ORDER_CNT_WIDTH = 8;
    localparam int TICK_CNT_WIDTH  = 32;
    localparam int NUM_PHASES      = 3;

    localparam logic [LOSS_LIM_WIDTH-1:0]  LOSS_LIMIT_RESET     = 16'd100;
    localparam logic [SEQ_LIM_WIDTH-1:0]   SEQUENCE_LIMIT_RESET = 8'd10;
    localparam logic [ORDER_CNT_WIDTH-1:0] ORDER_MAX            = '1;

endpackage

>>> rtl/core/three_phase_loss_and_sequence_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_loss_and_sequence_detect
// Tracks per-phase loss on millisecond ticks and checks phase order on edges.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one event per transfer:
//   i_func selects a 1 ms tick or a sequence-check edge, with pin levels A/B/C.
//   Output channel (o_out_valid / i_out_stall) returns one status transfer per
//   input transfer: loss flags, sequence_right and the 32-bit tick count,
//   showing the state after that event.
//   Config channel (i_cfg_valid / o_cfg_ready) writes loss_limit (index 0) or
//   sequence_limit (index 1); other indexes are ignored. Write only when idle.
// Timing and throughput:
//   The status appears in the cycle after the input transfer; one event is
//   taken every cycle while the output is not stalled, limited only by the single result register.
// Stall:
//   While a result waits under i_out_stall, o_in_stall is raised; the held
//   result does not change.
// Reset:
//   Synchronous, active low. All phases read lost, last levels high, counters
//   zero, limits back to 100 and 10, no result pending.
// ----------------------------------------------------------------------------
module three_phase_loss_and_sequence_detect #(
    parameter int LOSS_COUNT_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_func,
    input  logic                                  i_pin_a,
    input  logic                                  i_pin_b,
    input  logic                                  i_pin_c,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_loss_a,
    output logic                                  o_loss_b,
    output logic                                  o_loss_c,
    output logic                                  o_sequence_right,
    output logic [tpls_pkg::TICK_CNT_WIDTH-1:0]   o_tick_count,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tpls_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [tpls_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int NP    = tpls_pkg::NUM_PHASES;
    localparam int CMP_W = (LOSS_COUNT_WIDTH > tpls_pkg::LOSS_LIM_WIDTH) ?
                           LOSS_COUNT_WIDTH : tpls_pkg::LOSS_LIM_WIDTH;
    localparam logic [LOSS_COUNT_WIDTH-1:0] STILL_MAX = '1;

    logic [tpls_pkg::LOSS_LIM_WIDTH-1:0]   r_loss_limit;
    logic [tpls_pkg::SEQ_LIM_WIDTH-1:0]    r_seq_limit;

    logic [NP-1:0]                         r_last, n_last;
    logic [NP-1:0]                         r_lost, n_lost;
    logic [LOSS_COUNT_WIDTH-1:0]           r_still [NP];
    logic [LOSS_COUNT_WIDTH-1:0]           n_still [NP];
    logic                                  r_order_ok, n_order_ok;
    logic [tpls_pkg::ORDER_CNT_WIDTH-1:0]  r_order_cnt, n_order_cnt;
    logic [tpls_pkg::TICK_CNT_WIDTH-1:0]   r_ticks, n_ticks;

    logic                                  r_out_valid;
    logic [NP-1:0]                         r_out_lost;
    logic                                  r_out_seq;
    logic [tpls_pkg::TICK_CNT_WIDTH-1:0]   r_out_ticks;

    logic                                  in_xfer;
    logic [NP-1:0]                         pins;
    tpls_pkg::t_func                       func;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign pins        = {i_pin_c, i_pin_b, i_pin_a};
    assign func        = tpls_pkg::t_func'(i_func);

    always_comb begin
        n_last      = r_last;
        n_lost      = r_lost;
        n_still     = r_still;
        n_order_ok  = r_order_ok;
        n_order_cnt = r_order_cnt;
        n_ticks     = r_ticks;
        if (func == tpls_pkg::FUNC_TICK) begin
            n_ticks = r_ticks + 1'b1;
            for (int p = 0; p < NP; p++) begin
                if (r_last[p] != pins[p]) begin
                    n_last[p]  = pins[p];
                    n_still[p] = '0;
                    n_lost[p]  = 1'b0;
                end else begin
                    if (r_still[p] != STILL_MAX) begin
                        n_still[p] = r_still[p] + 1'b1;
                    end
                    if (CMP_W'(r_still[p]) > CMP_W'(r_loss_limit)) begin
                        n_lost[p] = 1'b1;
                    end
                end
            end
        end else if (r_lost == '0) begin
            if (i_pin_b && !i_pin_a) begin
                if (r_order_cnt != tpls_pkg::ORDER_MAX) begin
                    n_order_cnt = r_order_cnt + 1'b1;
                end
                n_order_ok = (r_order_cnt > r_seq_limit);
            end else begin
                n_order_ok  = 1'b0;
                n_order_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_limit <= tpls_pkg::LOSS_LIMIT_RESET;
            r_seq_limit  <= tpls_pkg::SEQUENCE_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tpls_pkg::CFG_LOSS_LIMIT: begin
                    r_loss_limit <= i_cfg_data[tpls_pkg::LOSS_LIM_WIDTH-1:0];
                end
                tpls_pkg::CFG_SEQUENCE_LIMIT: begin
                    r_seq_limit <= i_cfg_data[tpls_pkg::SEQ_LIM_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '1;
            r_lost      <= '1;
            r_still     <= '{default: '0};
            r_order_ok  <= 1'b0;
            r_order_cnt <= '0;
            r_ticks     <= '0;
        end else if (in_xfer) begin
            r_last      <= n_last;
            r_lost      <= n_lost;
            r_still     <= n_still;
            r_order_ok  <= n_order_ok;
            r_order_cnt <= n_order_cnt;
            r_ticks     <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_lost  <= n_lost;
            r_out_seq   <= n_order_ok;
            r_out_ticks <= n_ticks;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_loss_a         = r_out_lost[0];
    assign o_loss_b         = r_out_lost[1];
    assign o_loss_c         = r_out_lost[2];
    assign o_sequence_right = r_out_seq;
    assign o_tick_count     = r_out_ticks;

    // tick transfers advance the free-running count by one
    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && func == tpls_pkg::FUNC_TICK |=> r_ticks == $past(r_ticks) + 1'b1)
        else $error("tick count did not advance");

    // edge events leave order state alone while any phase is lost
    a_edge_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && func == tpls_pkg::FUNC_EDGE && r_lost != '0
        |=> $stable(r_order_ok) && $stable(r_order_cnt))
        else $error("order state changed while a phase is lost");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_order_ok |-> r_order_cnt != '0)
        else $error("sequence right with empty order count");

    // a loss flag is only raised by a tick
    a_lost_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_lost[0]) || $rose(r_lost[1]) || $rose(r_lost[2])
        |-> $past(in_xfer && func == tpls_pkg::FUNC_TICK))
        else $error("loss flag raised without a tick");

    // the result register reloads exactly on an input transfer
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid && r_out_ticks == r_ticks)
        else $error("result register out of step with state");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for three_phase_loss_and_sequence_detect. A short table
// of directed events and register writes is followed by random tick and edge
// streams under several limit settings and idle patterns. It ends with a run
// of good edges that drives the order counter into saturation. Every status
// transfer is compared field by field against an in-bench model of the
// detector, or against the table's expected status where a row gives one.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STILL_W = 16;
    localparam tpls_pkg::t_cfg_index CFG_SPARE_LO = tpls_pkg::t_cfg_index'(2);
    localparam tpls_pkg::t_cfg_index CFG_SPARE_HI = tpls_pkg::t_cfg_index'(3);

    typedef struct packed {
        logic                                loss_a;
        logic                                loss_b;
        logic                                loss_c;
        logic                                sequence_right;
        logic [tpls_pkg::TICK_CNT_WIDTH-1:0] tick_count;
    } t_status;

    typedef enum logic {
        ROW_EVENT = 1'b0,
        ROW_WRITE = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind                           kind;
        tpls_pkg::t_func                     func;
        logic [2:0]                          pins;
        logic                                typed;
        t_status                             want;
        tpls_pkg::t_cfg_index                idx;
        logic [tpls_pkg::CFG_DATA_WIDTH-1:0] data;
    } t_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic                                i_func = 1'b0;
    logic                                i_pin_a = 1'b0;
    logic                                i_pin_b = 1'b0;
    logic                                i_pin_c = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic                                o_loss_a;
    logic                                o_loss_b;
    logic                                o_loss_c;
    logic                                o_sequence_right;
    logic [tpls_pkg::TICK_CNT_WIDTH-1:0] o_tick_count;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    tpls_pkg::t_cfg_index                i_cfg_index = tpls_pkg::CFG_LOSS_LIMIT;
    logic [tpls_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data = '0;

    // detector model state
    logic [2:0]                           level_mem = 3'b111;
    logic [2:0]                           lost_mem = 3'b111;
    logic [STILL_W-1:0]                   still_cnt [3] = '{default: '0};
    logic                                 order_ok = 1'b0;
    logic [tpls_pkg::ORDER_CNT_WIDTH-1:0] order_cnt = '0;
    logic [tpls_pkg::TICK_CNT_WIDTH-1:0]  tick_cnt = '0;
    logic [tpls_pkg::LOSS_LIM_WIDTH-1:0]  lim_loss = tpls_pkg::LOSS_LIMIT_RESET;
    logic [tpls_pkg::SEQ_LIM_WIDTH-1:0]   lim_seq = tpls_pkg::SEQUENCE_LIMIT_RESET;

    t_status status_q [$];
    t_row    dir_rows [$];
    int      mismatch_cnt = 0;
    int      tx_idle_pct = 10;
    int      rx_idle_pct = 56;

    three_phase_loss_and_sequence_detect #(
        .LOSS_COUNT_WIDTH(STILL_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_pin_a         (i_pin_a),
        .i_pin_b         (i_pin_b),
        .i_pin_c         (i_pin_c),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_loss_a        (o_loss_a),
        .o_loss_b        (o_loss_b),
        .o_loss_c        (o_loss_c),
        .o_sequence_right(o_sequence_right),
        .o_tick_count    (o_tick_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_status detector_step(tpls_pkg::t_func f, logic [2:0] pins);
        logic [STILL_W-1:0]                   old_still;
        logic [tpls_pkg::ORDER_CNT_WIDTH-1:0] old_order;
        if (f == tpls_pkg::FUNC_TICK) begin
            tick_cnt = tick_cnt + 1'b1;
            for (int p = 0; p < tpls_pkg::NUM_PHASES; p++) begin
                if (level_mem[p] != pins[p]) begin
                    level_mem[p] = pins[p];
                    still_cnt[p] = '0;
                    lost_mem[p]  = 1'b0;
                end else begin
                    old_still = still_cnt[p];
                    if (old_still != '1)
                        still_cnt[p] = old_still + 1'b1;
                    if (old_still > lim_loss)
                        lost_mem[p] = 1'b1;
                end
            end
        end else if (lost_mem == 3'b000) begin
            if (pins[1] && !pins[0]) begin
                old_order = order_cnt;
                if (old_order != tpls_pkg::ORDER_MAX)
                    order_cnt = old_order + 1'b1;
                order_ok = (old_order > lim_seq);
            end else begin
                order_ok  = 1'b0;
                order_cnt = '0;
            end
        end
        return '{lost_mem[0], lost_mem[1], lost_mem[2], order_ok, tick_cnt};
    endfunction

    function automatic t_row event_row(tpls_pkg::t_func f, logic [2:0] pins);
        return '{ROW_EVENT, f, pins, 1'b0, '0, tpls_pkg::CFG_LOSS_LIMIT, '0};
    endfunction

    function automatic t_row typed_row(tpls_pkg::t_func f, logic [2:0] pins,
                                       t_status want);
        return '{ROW_EVENT, f, pins, 1'b1, want, tpls_pkg::CFG_LOSS_LIMIT, '0};
    endfunction

    function automatic t_row write_row(tpls_pkg::t_cfg_index idx,
                                       logic [tpls_pkg::CFG_DATA_WIDTH-1:0] data);
        return '{ROW_WRITE, tpls_pkg::FUNC_TICK, 3'b000, 1'b0, '0, idx, data};
    endfunction

    task automatic send_event(tpls_pkg::t_func f, logic [2:0] pins, logic typed,
                              t_status want);
        t_status pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_pin_a    <= pins[0];
        i_pin_b    <= pins[1];
        i_pin_c    <= pins[2];
        do @(posedge i_clk); while (o_in_stall);
        pred = detector_step(f, pins);
        status_q.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(tpls_pkg::t_cfg_index idx,
                             logic [tpls_pkg::CFG_DATA_WIDTH-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tpls_pkg::CFG_LOSS_LIMIT:     lim_loss = data;
            tpls_pkg::CFG_SEQUENCE_LIMIT: lim_seq  = data[tpls_pkg::SEQ_LIM_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                $display("%0t: status transfer with none expected", $time);
                mismatch_cnt++;
            end else begin
                want = status_q.pop_front();
                report_field("loss_a", 32'(want.loss_a), 32'(o_loss_a));
                report_field("loss_b", 32'(want.loss_b), 32'(o_loss_b));
                report_field("loss_c", 32'(want.loss_c), 32'(o_loss_c));
                report_field("sequence_right", 32'(want.sequence_right),
                             32'(o_sequence_right));
                report_field("tick_count", want.tick_count, o_tick_count);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        logic [2:0]      pin_lvl;
        logic [2:0]      stuck;
        logic [2:0]      pins;
        tpls_pkg::t_func f;

        // after reset all phases read lost and edges are ignored
        dir_rows.push_back(typed_row(tpls_pkg::FUNC_EDGE, 3'b010,
                                     '{1'b1, 1'b1, 1'b1, 1'b0, 32'd0}));
        dir_rows.push_back(typed_row(tpls_pkg::FUNC_TICK, 3'b111,
                                     '{1'b1, 1'b1, 1'b1, 1'b0, 32'd1}));
        dir_rows.push_back(typed_row(tpls_pkg::FUNC_TICK, 3'b000,
                                     '{1'b0, 1'b0, 1'b0, 1'b0, 32'd2}));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b010));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b111));
        dir_rows.push_back(write_row(tpls_pkg::CFG_LOSS_LIMIT, 16'h0000));
        dir_rows.push_back(write_row(tpls_pkg::CFG_SEQUENCE_LIMIT, 16'h0000));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_TICK, 3'b000));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_TICK, 3'b000));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b010));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_TICK, 3'b101));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_TICK, 3'b111));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b010));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b110));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b001));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b010));
        dir_rows.push_back(write_row(tpls_pkg::CFG_SEQUENCE_LIMIT, 16'hFFFF));
        dir_rows.push_back(write_row(tpls_pkg::CFG_LOSS_LIMIT, 16'hFFFF));
        dir_rows.push_back(write_row(CFG_SPARE_LO, 16'h5A5A));
        dir_rows.push_back(write_row(CFG_SPARE_HI, 16'hFFFF));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b010));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b110));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_TICK, 3'b111));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_TICK, 3'b111));
        dir_rows.push_back(write_row(tpls_pkg::CFG_LOSS_LIMIT, 16'hFFFE));
        dir_rows.push_back(write_row(tpls_pkg::CFG_SEQUENCE_LIMIT, 16'h00FE));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_TICK, 3'b000));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b011));
        dir_rows.push_back(event_row(tpls_pkg::FUNC_EDGE, 3'b000));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_event(dir_rows[i].func, dir_rows[i].pins, dir_rows[i].typed,
                           dir_rows[i].want);
        end

        pin_lvl = level_mem;
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 56 : 0;
            rx_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 10 : 0;
            for (int seg = 0; seg < 5; seg++) begin
                write_reg(tpls_pkg::CFG_LOSS_LIMIT, ($urandom_range(0, 9) == 0) ?
                          16'($urandom) : 16'($urandom_range(0, 12)));
                write_reg(tpls_pkg::CFG_SEQUENCE_LIMIT, ($urandom_range(0, 9) == 0) ?
                          16'($urandom) :
                          {8'($urandom), 8'($urandom_range(0, 6))});
                if ($urandom_range(0, 3) == 0)
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                              16'($urandom));
                stuck = ($urandom_range(0, 1) == 0) ? 3'b000 : 3'($urandom_range(1, 7));
                for (int n = 0; n < 50; n++) begin
                    if ($urandom_range(0, 99) < 40) begin
                        f    = tpls_pkg::FUNC_EDGE;
                        pins = ($urandom_range(0, 3) != 0) ?
                               {1'($urandom), 2'b10} : 3'($urandom);
                    end else begin
                        f = tpls_pkg::FUNC_TICK;
                        if ($urandom_range(0, 9) == 0) begin
                            pin_lvl = 3'($urandom);
                        end else begin
                            for (int p = 0; p < tpls_pkg::NUM_PHASES; p++)
                                if (!stuck[p] && $urandom_range(0, 99) < 60)
                                    pin_lvl[p] = !pin_lvl[p];
                        end
                        pins = pin_lvl;
                    end
                    send_event(f, pins, 1'b0, '0);
                end
            end
        end

        // order counter saturation with limits one below the counter maximum
        write_reg(tpls_pkg::CFG_LOSS_LIMIT, 16'hFFFE);
        write_reg(tpls_pkg::CFG_SEQUENCE_LIMIT, 16'h00FE);
        send_event(tpls_pkg::FUNC_TICK, 3'b111, 1'b0, '0);
        send_event(tpls_pkg::FUNC_TICK, 3'b000, 1'b0, '0);
        for (int n = 0; n < 260; n++)
            send_event(tpls_pkg::FUNC_EDGE, {1'($urandom), 2'b10}, 1'b0, '0);
        for (int n = 0; n < 4; n++)
            send_event(tpls_pkg::FUNC_TICK, 3'b000, 1'b0, '0);
        send_event(tpls_pkg::FUNC_EDGE, 3'b000, 1'b0, '0);

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
